// ===== hdl/glyph_text_line_layout_assert.svh =====
// Assertion macros used by the checker module.
`ifndef GLYPH_TEXT_LINE_LAYOUT_ASSERT_SVH
`define GLYPH_TEXT_LINE_LAYOUT_ASSERT_SVH
// Implication checked on every clock, held off during reset.
`define GTL_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);
// Next-cycle implication checked on every clock, held off during reset.
`define GTL_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error(msg);
`endif

// ===== hdl/gtl_pkg.sv =====
`timescale 1ns / 1ps
package gtl_pkg;
  localparam int GLYPH_DEPTH_DEF = 256;
  localparam logic [20:0] NEWLINE_CODE = 21'd10;
  localparam int COORD_W = 24;
  localparam int METRIC_W = 53;
  localparam int ENTRY_W = 21 + 53;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_PLACE  = 2'd1,
    CMD_BEGIN  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_FONT_SIZE   = 3'd0,
    REG_ORIG_SIZE   = 3'd1,
    REG_LINE_ADV    = 3'd2,
    REG_MAX_WIDTH   = 3'd3,
    REG_WRAP_ENABLE = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT,
    ST_SCALE_REQ,
    ST_SCALE_WAIT,
    ST_WRAP,
    ST_BOX,
    ST_NEWLINE,
    ST_OUT
  } state_t;

  // Control between sequencer and divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [26:0] v);
    logic signed [26:0] hi;
    logic signed [26:0] lo;
    hi = 27'sd8388607;
    lo = -27'sd8388608;
    if (v > hi) return COORD_W'(hi);
    else if (v < lo) return COORD_W'(lo);
    else return v[COORD_W-1:0];
  endfunction
endpackage

// ===== hdl/gtl_ram.sv =====
`timescale 1ns / 1ps
module gtl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/gtl_scale_div.sv =====
`timescale 1ns / 1ps
module gtl_scale_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gtl_pkg::div_ctl_t    ctl,
  input  logic [10:0]          mag,
  input  logic [9:0]           num,
  input  logic [9:0]           den,
  output gtl_pkg::div_sts_t    sts,
  output logic [20:0]          quot
);
  import gtl_pkg::*;
  // Dividend 2*mag*num+den < 2^33, divisor 2*den < 2^11: restoring, one bit a cycle.
  logic [32:0] rem_r, rem_nxt;
  logic [10:0] dvs_r, dvs_nxt;
  logic [32:0] dvd_r, dvd_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [21:0] prod;
  logic [33:0] trial;

  assign prod = {11'd0, mag} * {12'd0, num};

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[32]} - {23'd0, dvs_r};
    if (ctl.start) begin
      dvd_nxt  = {10'd0, prod, 1'b0} + {23'd0, den};
      dvs_nxt  = {den, 1'b0};
      rem_nxt  = '0;
      cnt_nxt  = 6'd33;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift one dividend bit in and subtract when it fits.
      if (!trial[33]) rem_nxt = trial[32:0];
      else rem_nxt = {rem_r[31:0], dvd_r[32]};
      dvd_nxt = {dvd_r[31:0], !trial[33]};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = dvd_r[20:0];
endmodule

// ===== hdl/glyph_text_line_layout.sv =====
`timescale 1ns / 1ps
// Glyph text line layout. Append commands fill a glyph table (GLYPH_DEPTH
// entries); place commands look a code point up, scale its metrics by
// font_size/original_size and emit a character box with character wrap.
// Sequence: an append, a begin or an unused command is handled in the idle state. A
// place transaction scans the table through the registered-read RAM, a search and a
// wait state for each entry (ending with no box when the code is not found), then runs
// six scaling divides on one shared bit-serial divider, then the wrap and box states.
// A newline skips the scan and needs one divide plus the newline state. The result
// register holds a box until it is taken; no new transaction is accepted while an
// item is in flight.
module glyph_text_line_layout #(
  parameter int GLYPH_DEPTH = gtl_pkg::GLYPH_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [20:0] in_code_point,
  input  logic [9:0]  in_glyph_width,
  input  logic [9:0]  in_glyph_height,
  input  logic signed [10:0] in_glyph_x_offset,
  input  logic signed [10:0] in_glyph_y_offset,
  input  logic signed [10:0] in_glyph_advance,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_char_position,
  output logic signed [23:0] out_row_top,
  output logic signed [23:0] out_box_left,
  output logic signed [23:0] out_box_top,
  output logic signed [23:0] out_box_right,
  output logic signed [23:0] out_box_bottom
);
  import gtl_pkg::*;
  localparam int AW = (GLYPH_DEPTH > 1) ? $clog2(GLYPH_DEPTH) : 1;
  localparam int CW = $clog2(GLYPH_DEPTH + 1);

  // Configuration registers.
  logic [9:0]  font_size_r, orig_size_r;
  logic [10:0] line_adv_r;
  logic [15:0] max_width_r;
  logic        wrap_en_r;
  logic [9:0]  num, den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_size_r <= 10'd12;
      orig_size_r <= 10'd12;
      line_adv_r  <= '0;
      max_width_r <= 16'hFFFF;
      wrap_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT_SIZE:   font_size_r <= cfg_wdata[9:0];
        REG_ORIG_SIZE:   orig_size_r <= cfg_wdata[9:0];
        REG_LINE_ADV:    line_adv_r  <= cfg_wdata[10:0];
        REG_MAX_WIDTH:   max_width_r <= cfg_wdata;
        REG_WRAP_ENABLE: wrap_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end
  assign num = (font_size_r == '0) ? 10'd1 : font_size_r;
  assign den = (orig_size_r == '0) ? 10'd1 : orig_size_r;

  // State.
  state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic signed [23:0] pen_r, row_r;
  logic [15:0] pos_r;
  logic [AW-1:0] idx_r;
  logic [CW-1:0] scan_r;
  logic          hit_r;
  logic [2:0]  sel_r;
  logic        is_last_r, is_nl_r;
  logic [20:0] code_r;
  logic signed [21:0] sc_r [6];
  logic [METRIC_W-1:0] met_r;

  logic        accept;
  logic        ram_we;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [AW-1:0] ram_raddr;
  div_ctl_t    dctl;
  div_sts_t    dsts;
  logic [20:0] quot;
  logic signed [10:0] raw;
  logic [10:0] mag;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || out_valid;
  assign ram_we = accept && (in_cmd == CMD_APPEND) && (count_r < CW'(GLYPH_DEPTH));

  gtl_ram #(.WIDTH(ENTRY_W), .DEPTH(GLYPH_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[AW-1:0]),
    .wdata ({in_code_point, in_glyph_advance, in_glyph_y_offset, in_glyph_x_offset,
             in_glyph_height, in_glyph_width}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );
  assign ram_raddr = idx_r;

  // Select the raw value for divide slot sel (0 line advance, 1..5 metrics).
  always_comb begin
    case (sel_r)
      3'd1:    raw = {1'b0, met_r[9:0]};
      3'd2:    raw = {1'b0, met_r[19:10]};
      3'd3:    raw = met_r[30:20];
      3'd4:    raw = met_r[41:31];
      3'd5:    raw = met_r[52:42];
      default: raw = line_adv_r[10:0] ^ 11'd0;
    endcase
    if (sel_r == 3'd0) mag = line_adv_r;
    else mag = raw[10] ? 11'(-raw) : raw;
  end

  gtl_scale_div u_div (
    .clk (clk), .rst_n (rst_n), .ctl (dctl), .mag (mag), .num (num), .den (den),
    .sts (dsts), .quot (quot)
  );

  logic last_slot;
  assign last_slot = is_nl_r ? 1'b1 : (sel_r == 3'd5);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (accept && in_cmd == CMD_PLACE) begin
          if (in_code_point == NEWLINE_CODE) state_nxt = ST_SCALE_REQ;
          else state_nxt = ST_SEARCH;
        end
      ST_SEARCH:     state_nxt = (scan_r == count_r) ? ST_IDLE : ST_WAIT;
      ST_WAIT:       state_nxt = ST_SEARCH;
      ST_SCALE_REQ:  state_nxt = ST_SCALE_WAIT;
      ST_SCALE_WAIT:
        if (dsts.done) begin
          if (last_slot) state_nxt = is_nl_r ? ST_NEWLINE : ST_WRAP;
          else state_nxt = ST_SCALE_REQ;
        end
      ST_WRAP:       state_nxt = ST_BOX;
      ST_BOX:        state_nxt = ST_IDLE;
      ST_NEWLINE:    state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_SEARCH && scan_r != count_r && hit_r) state_nxt = ST_SCALE_REQ;
  end

  // Outputs of the sequencer.
  always_comb begin
    dctl.start = (state_r == ST_SCALE_REQ);
  end

  // Datapath.
  logic signed [26:0] wide_a;
  logic signed [23:0] vadv, w, h, xo, yo, adv;
  logic               vis;
  logic               ov_r;
  logic [15:0]        ocp_r;
  logic signed [23:0] o_row_r, o_l_r, o_t_r, o_r_r, o_b_r;

  assign vadv = 24'(sc_r[0]);
  assign w    = 24'(sc_r[1]);
  assign h    = 24'(sc_r[2]);
  assign xo   = 24'(sc_r[3]);
  assign yo   = 24'(sc_r[4]);
  assign adv  = 24'(sc_r[5]);
  assign vis  = (w > 0) && (h > 0);

  // Advance the pen; a visible glyph at the line start drops its x bearing.
  assign wide_a = 27'(pen_r) + 27'(adv) - ((vis && pen_r == 0) ? 27'(xo) : 27'sd0);

  logic signed [21:0] sval;
  assign sval = (sel_r != 3'd0 && raw[10]) ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  logic [15:0] pos_inc;
  assign pos_inc = (pos_r == 16'hFFFF) ? pos_r : pos_r + 16'd1;

  logic signed [23:0] row_adv;
  assign row_adv = sat24(27'(row_r) + 27'(vadv));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pen_r   <= '0;
      row_r   <= '0;
      pos_r   <= '0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
      scan_r  <= '0;
      hit_r   <= 1'b0;
      sel_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (accept) begin
          code_r    <= in_code_point;
          is_last_r <= in_is_last;
          is_nl_r   <= (in_code_point == NEWLINE_CODE);
          idx_r     <= '0;
          scan_r    <= '0;
          hit_r     <= 1'b0;
          sel_r     <= '0;
          case (in_cmd)
            CMD_APPEND: if (ram_we) count_r <= count_r + CW'(1);
            CMD_BEGIN: begin
              pen_r <= '0;
              row_r <= '0;
              pos_r <= '0;
            end
            default: ;
          endcase
        end
        ST_SEARCH: begin
          if (scan_r == count_r) pos_r <= pos_inc;
          else hit_r <= 1'b0;
        end
        ST_WAIT: begin
          // Compare the registered entry read for this scan slot.
          if (ram_rdata[ENTRY_W-1 -: 21] == code_r) begin
            hit_r <= 1'b1;
            met_r <= ram_rdata[METRIC_W-1:0];
          end else begin
            scan_r <= scan_r + CW'(1);
            idx_r  <= idx_r + AW'(1);
          end
        end
        ST_SCALE_WAIT: if (dsts.done) begin
          sc_r[sel_r] <= sval;
          sel_r <= sel_r + 3'd1;
        end
        ST_WRAP: if (wrap_en_r && (27'(pen_r) + 27'(w) >= $signed({11'd0, max_width_r}))) begin
          pen_r <= '0;
          row_r <= row_adv;
        end
        ST_BOX: begin
          if (vis) begin
            ov_r    <= 1'b1;
            ocp_r   <= pos_r;
            o_row_r <= row_r;
            if (pen_r != 0) begin
              o_l_r <= sat24(27'(pen_r) + 27'(xo));
              o_r_r <= sat24(27'(pen_r) + 27'(xo) + 27'(w));
            end else begin
              o_l_r <= '0;
              o_r_r <= w;
            end
            o_t_r <= sat24(27'(row_r) + 27'(yo));
            o_b_r <= sat24(27'(row_r) + 27'(yo) + 27'(h));
          end
          pen_r <= sat24(wide_a);
          pos_r <= pos_inc;
        end
        ST_NEWLINE: begin
          ov_r  <= 1'b1;
          ocp_r <= pos_r;
          if (is_last_r) begin
            o_row_r <= row_adv; o_l_r <= '0; o_t_r <= row_adv;
            o_r_r <= '0; o_b_r <= row_adv;
          end else begin
            o_row_r <= row_r; o_l_r <= pen_r; o_t_r <= row_r;
            o_r_r <= pen_r; o_b_r <= row_r;
          end
          pen_r <= '0;
          row_r <= row_adv;
          pos_r <= pos_inc;
        end
        default: ;
      endcase
    end
  end

  assign out_valid         = ov_r;
  assign out_char_position = ocp_r;
  assign out_row_top       = o_row_r;
  assign out_box_left      = o_l_r;
  assign out_box_top       = o_t_r;
  assign out_box_right     = o_r_r;
  assign out_box_bottom    = o_b_r;
endmodule

// ===== hdl/gtl_checker.sv =====
`timescale 1ns / 1ps
`include "glyph_text_line_layout_assert.svh"
module gtl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_char_position,
  input logic signed [23:0] out_box_left,
  input logic signed [23:0] out_box_right,
  input logic signed [23:0] out_box_top,
  input logic signed [23:0] out_box_bottom
);
  import gtl_pkg::*;

  logic held, place_taken, box_ok;

  // Qualify the handshakes and the box bounds.
  assign held        = out_valid && out_stall;
  assign place_taken = in_valid && !in_stall && (in_cmd == CMD_PLACE);
  assign box_ok      = (out_box_left <= out_box_right) && (out_box_top <= out_box_bottom);

  `GTL_ASSERT_NXT(a_hold, clk, rst_n, held, out_valid && $stable(out_char_position), "moved")
  `GTL_ASSERT_IMP(a_busy_out, clk, rst_n, out_valid, in_stall, "input taken with result pending")
  `GTL_ASSERT_NXT(a_place_busy, clk, rst_n, place_taken, in_stall, "taken while placing")
  `GTL_ASSERT_IMP(a_box_order, clk, rst_n, out_valid, box_ok, "box bounds inverted")
endmodule

bind glyph_text_line_layout gtl_checker u_gtl_checker (
  .clk (clk), .rst_n (rst_n), .in_valid (in_valid), .in_stall (in_stall),
  .in_cmd (in_cmd),
  .out_valid (out_valid), .out_stall (out_stall), .out_char_position (out_char_position),
  .out_box_left (out_box_left), .out_box_right (out_box_right),
  .out_box_top (out_box_top), .out_box_bottom (out_box_bottom)
);

// ===== tb/sv/glyph_text_line_layout_checker.sv =====
`timescale 1ns / 1ps
module glyph_text_line_layout_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic [20:0]        in_code_point,
  input  logic [9:0]         in_glyph_width,
  input  logic [9:0]         in_glyph_height,
  input  logic signed [10:0] in_glyph_x_offset,
  input  logic signed [10:0] in_glyph_y_offset,
  input  logic signed [10:0] in_glyph_advance,
  input  logic               in_is_last,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [15:0]        out_char_position,
  input  logic signed [23:0] out_row_top,
  input  logic signed [23:0] out_box_left,
  input  logic signed [23:0] out_box_top,
  input  logic signed [23:0] out_box_right,
  input  logic signed [23:0] out_box_bottom,
  output int                 errors,
  output int                 pending
);
  import gtl_pkg::*;

  typedef struct {
    logic [15:0]        pos;
    logic signed [23:0] row;
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic signed [23:0] right;
    logic signed [23:0] bottom;
  } char_box_t;

  char_box_t box_q[$];

  // Glyph table mirror
  logic [20:0] tbl_code[256];
  int          tbl_w[256];
  int          tbl_h[256];
  int          tbl_xo[256];
  int          tbl_yo[256];
  int          tbl_adv[256];
  int          tbl_count = 0;

  // Layout state and registers
  longint pen = 0;
  longint row = 0;
  int     char_pos = 0;
  int     font_sz = 12;
  int     orig_sz = 12;
  int     line_raw = 0;
  int     wrap_lim = 65535;
  bit     wrap_on = 0;

  assign pending = box_q.size();

  function automatic longint clamp24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint scaled(input longint v);
    longint num, den, mag, q;
    num = (font_sz != 0) ? font_sz : 1;
    den = (orig_sz != 0) ? orig_sz : 1;
    mag = (v < 0) ? -v : v;
    q = (2 * mag * num + den) / (2 * den);
    return (v < 0) ? -q : q;
  endfunction

  function automatic char_box_t make_box(input longint r, input longint l, input longint t,
                                         input longint rt, input longint b);
    char_box_t bx;
    bx.pos = char_pos[15:0];
    bx.row = 24'(clamp24(r));
    bx.left = 24'(clamp24(l));
    bx.top = 24'(clamp24(t));
    bx.right = 24'(clamp24(rt));
    bx.bottom = 24'(clamp24(b));
    return bx;
  endfunction

  // Queue one expected box at the tail
  function automatic void expect_box(input char_box_t bx);
    box_q.insert(box_q.size(), bx);
  endfunction

  function automatic void step_pos();
    if (char_pos < 65535) char_pos++;
  endfunction

  // Advance the layout by one accepted transaction, queue any box it makes
  function automatic void layout_item();
    longint vadv, w, h, xo, yo, adv, extra;
    int hit;
    extra = 0;
    hit = -1;
    case (cmd_t'(in_cmd))
      CMD_APPEND: begin
        if (tbl_count < 256) begin
          tbl_code[tbl_count] = in_code_point;
          tbl_w[tbl_count] = int'(in_glyph_width);
          tbl_h[tbl_count] = int'(in_glyph_height);
          tbl_xo[tbl_count] = int'(in_glyph_x_offset);
          tbl_yo[tbl_count] = int'(in_glyph_y_offset);
          tbl_adv[tbl_count] = int'(in_glyph_advance);
          tbl_count++;
        end
      end
      CMD_BEGIN: begin
        pen = 0;
        row = 0;
        char_pos = 0;
      end
      CMD_PLACE: begin
        vadv = scaled(line_raw);
        if (in_code_point == NEWLINE_CODE) begin
          if (!in_is_last) expect_box(make_box(row, pen, row, pen, row));
          pen = 0;
          row = clamp24(row + vadv);
          if (in_is_last) expect_box(make_box(row, 0, row, 0, row));
          step_pos();
        end else begin
          for (int i = 0; i < tbl_count; i++)
            if (hit < 0 && tbl_code[i] == in_code_point) hit = i;
          if (hit < 0) begin
            step_pos();
          end else begin
            w = scaled(tbl_w[hit]);
            h = scaled(tbl_h[hit]);
            xo = scaled(tbl_xo[hit]);
            yo = scaled(tbl_yo[hit]);
            adv = scaled(tbl_adv[hit]);
            // Character wrap onto a new row
            if (wrap_on && pen + w >= wrap_lim) begin
              pen = 0;
              row = clamp24(row + vadv);
            end
            if (w > 0 && h > 0) begin
              if (pen != 0) begin
                expect_box(make_box(row, pen + xo, row + yo, pen + xo + w, row + yo + h));
              end else begin
                extra = -xo;
                expect_box(make_box(row, pen, row + yo, pen + w, row + yo + h));
              end
            end
            pen = clamp24(pen + adv + extra);
            step_pos();
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    char_box_t want;
    if (!rst_n) begin
      errors = 0;
    end else begin
      // Compare the result transaction against the oldest expected box
      if (out_valid && !out_stall) begin
        if (box_q.size() == 0) begin
          report_mismatch("unexpected box at position", out_char_position, 0);
        end else begin
          want = box_q.pop_front();
          if (out_char_position !== want.pos)
            report_mismatch("char_position", out_char_position, want.pos);
          if (out_row_top !== want.row) report_mismatch("row_top", out_row_top, want.row);
          if (out_box_left !== want.left) report_mismatch("box_left", out_box_left, want.left);
          if (out_box_top !== want.top) report_mismatch("box_top", out_box_top, want.top);
          if (out_box_right !== want.right)
            report_mismatch("box_right", out_box_right, want.right);
          if (out_box_bottom !== want.bottom)
            report_mismatch("box_bottom", out_box_bottom, want.bottom);
        end
      end
      if (in_valid && !in_stall) layout_item();
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_FONT_SIZE:   font_sz = int'(cfg_wdata[9:0]);
          REG_ORIG_SIZE:   orig_sz = int'(cfg_wdata[9:0]);
          REG_LINE_ADV:    line_raw = int'(cfg_wdata[10:0]);
          REG_MAX_WIDTH:   wrap_lim = int'(cfg_wdata);
          REG_WRAP_ENABLE: wrap_on = cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/glyph_text_line_layout_tb.sv =====
`timescale 1ns / 1ps
module glyph_text_line_layout_tb;
  import gtl_pkg::*;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [1:0]         in_cmd = CMD_BEGIN;
  logic [20:0]        in_code_point = '0;
  logic [9:0]         in_glyph_width = '0;
  logic [9:0]         in_glyph_height = '0;
  logic signed [10:0] in_glyph_x_offset = '0;
  logic signed [10:0] in_glyph_y_offset = '0;
  logic signed [10:0] in_glyph_advance = '0;
  logic               in_is_last = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [15:0]        out_char_position;
  logic signed [23:0] out_row_top, out_box_left, out_box_top, out_box_right, out_box_bottom;
  int                 errors;
  int                 pending;

  int          tx_pct = 0;
  int          rx_pct = 0;
  logic [20:0] code_pool[$];

  glyph_text_line_layout dut (.*);
  glyph_text_line_layout_checker u_checker (.*);

  always #5 clk = ~clk;

  // Receiver stall pattern
  always @(posedge clk) out_stall <= ($urandom_range(99) < rx_pct);

  initial begin
    #50_000_000;
    $display("glyph_text_line_layout_tb NOT OK");
    $finish;
  end

  // Present one register write for a single clock
  task automatic write_reg(input reg_idx_t idx, input int value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value[15:0];
    @(posedge clk);
  endtask

  task automatic apply_settings(input int fs, input int os, input int la, input int mw,
                                input int we);
    write_reg(REG_FONT_SIZE, fs);
    write_reg(REG_ORIG_SIZE, os);
    write_reg(REG_LINE_ADV, la);
    write_reg(REG_MAX_WIDTH, mw);
    write_reg(REG_WRAP_ENABLE, we);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Drive one transaction and hold it until accepted
  task automatic send(input cmd_t c, input logic [20:0] cp, input int w, input int h,
                      input int xo, input int yo, input int adv, input bit last);
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < tx_pct) @(posedge clk);
    end
    in_valid <= 1;
    in_cmd <= c;
    in_code_point <= cp;
    in_glyph_width <= w[9:0];
    in_glyph_height <= h[9:0];
    in_glyph_x_offset <= xo[10:0];
    in_glyph_y_offset <= yo[10:0];
    in_glyph_advance <= adv[10:0];
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c == CMD_APPEND && code_pool.size() < 256) code_pool.insert(code_pool.size(), cp);
  endtask

  // Wait until every result is out and the block is idle again
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0 || in_stall) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic random_item();
    int sel;
    logic [20:0] cp;
    sel = $urandom_range(99);
    if (sel < 20) begin
      send(CMD_APPEND, 21'($urandom_range(1114111)),
           ($urandom_range(9) == 0) ? 0 : $urandom_range(1023),
           ($urandom_range(9) == 0) ? 0 : $urandom_range(1023),
           $urandom, $urandom, $urandom, 1'($urandom));
    end else if (sel < 92) begin
      sel = $urandom_range(99);
      if (sel < 75 && code_pool.size() > 0) cp = code_pool[$urandom_range(code_pool.size() - 1)];
      else if (sel < 88) cp = NEWLINE_CODE;
      else cp = 21'($urandom_range(1114111));
      send(CMD_PLACE, cp, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom_range(7) == 0);
    end else if (sel < 97) begin
      send(CMD_BEGIN, 21'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
           1'($urandom));
    end else begin
      send(CMD_NONE, 21'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
           1'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty-table lookup, extremes, newlines, invisible glyphs
    apply_settings(12, 12, 20, 65535, 0);
    send(CMD_PLACE, 21'h41, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, NEWLINE_CODE, 0, 0, 0, 0, 0, 0);
    send(CMD_APPEND, 21'h41, 1023, 1023, 1023, 1023, 1023, 0);
    send(CMD_APPEND, 21'h42, 1, 1, -1024, -1024, -1024, 1);
    send(CMD_APPEND, 21'h43, 0, 50, 5, 5, 30, 0);
    send(CMD_APPEND, 21'h44, 40, 0, -5, -5, 30, 0);
    send(CMD_APPEND, 21'h10FFFF, 10, 10, 3, -3, 12, 0);
    send(CMD_APPEND, 21'h41, 7, 7, 0, 0, 7, 0);
    send(CMD_PLACE, 21'h41, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, 21'h10FFFF, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, 21'h43, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, 21'h44, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, 21'h42, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, 21'h1234, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, NEWLINE_CODE, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, 21'h10FFFF, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, NEWLINE_CODE, 0, 0, 0, 0, 0, 1);
    send(CMD_NONE, 21'h41, 0, 0, 0, 0, 0, 0);
    send(CMD_BEGIN, 0, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, 21'h41, 0, 0, 0, 0, 0, 1);
    drain();
    apply_settings(1023, 1, 2047, 0, 1);
    repeat (4) send(CMD_PLACE, 21'h41, 0, 0, 0, 0, 0, 0);
    send(CMD_PLACE, NEWLINE_CODE, 0, 0, 0, 0, 0, 0);
    drain();

    // Random phases over several register settings and idling patterns
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: apply_settings(12, 12, 0, 65535, 0);
        1: apply_settings(1023, 1, 2047, 0, 1);
        2: apply_settings(1, 1023, 1, 100, 1);
        3: apply_settings(0, 0, 5, 65535, 1);
        default: apply_settings($urandom_range(1, 1023), $urandom_range(1, 1023),
                                $urandom_range(2047), $urandom_range(65535), $urandom_range(1));
      endcase
      case (ph % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 75; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 75; end
        default: begin tx_pct = 17; rx_pct = 17; end
      endcase
      for (int n = 0; n < 165; n++) begin
        // Hold off until the block has delivered everything
        if (ph == 5 && n == 80) begin
          in_valid <= 0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
        random_item();
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("glyph_text_line_layout_tb OK");
    end else begin
      $display("glyph_text_line_layout_tb NOT OK");
    end
    $finish;
  end
endmodule
